/* hw/rtl/bcdalu_pkg.sv */
// Package with the request, result and pipeline stage types of the BCD add/subtract ALU.
`timescale 1ns / 1ps

package bcdalu_pkg;

  localparam logic FuncAdc = 1'b0;
  localparam logic FuncSbc = 1'b1;

  localparam logic [3:0] BcdMaxDigit = 4'd9;
  localparam logic [3:0] BcdAdjust   = 4'd6;

  typedef struct packed {
    logic       func;
    logic [7:0] acc_in;
    logic [7:0] operand;
    logic       carry_in;
    logic       decimal_mode;
  } bcdalu_req_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic       carry_out;
    logic       overflow_out;
    logic       negative_out;
    logic       zero_out;
    logic       extra_cycle;
  } bcdalu_res_t;

  // After the low nibble step: the corrected low digit and its carry or borrow.
  typedef struct packed {
    logic       func;
    logic       dec;
    logic       cin;
    logic [7:0] acc;
    logic [7:0] opnd;
    logic [3:0] lo_nib;
    logic       lo_cb;
  } bcdalu_s1_t;

  // After the high nibble step: decimal high part plus the full binary result.
  typedef struct packed {
    logic       func;
    logic       dec;
    logic [3:0] lo_nib;
    logic [4:0] hi_part;
    logic [7:0] bin_res;
    logic       bin_c;
    logic       ovf;
  } bcdalu_s2_t;

endpackage

/* hw/rtl/bcdalu_lo.sv */
// First pipeline stage: low nibble sum or difference with decimal correction.
`timescale 1ns / 1ps

module bcdalu_lo
  import bcdalu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  bcdalu_req_t req_i,
  output logic        valid_o,
  output bcdalu_s1_t  s1_o
);

  logic       valid_q;
  bcdalu_s1_t s1_d, s1_q;
  logic [4:0] add_lo;
  logic [5:0] add_adj;
  logic [4:0] sub_lo;
  logic       borrow;

  always_comb begin
    borrow  = ~req_i.carry_in;
    add_lo  = {1'b0, req_i.acc_in[3:0]} + {1'b0, req_i.operand[3:0]}
              + {4'd0, req_i.carry_in};
    add_adj = (add_lo > {1'b0, BcdMaxDigit}) ? ({1'b0, add_lo} + {2'd0, BcdAdjust})
                                              : {1'b0, add_lo};
    sub_lo  = {1'b0, req_i.acc_in[3:0]} - {1'b0, req_i.operand[3:0]} - {4'd0, borrow};

    s1_d.func = req_i.func;
    s1_d.dec  = req_i.decimal_mode;
    s1_d.cin  = req_i.carry_in;
    s1_d.acc  = req_i.acc_in;
    s1_d.opnd = req_i.operand;
    if (req_i.func == FuncSbc) begin
      s1_d.lo_cb  = sub_lo[4];
      s1_d.lo_nib = sub_lo[4] ? (sub_lo[3:0] - BcdAdjust) : sub_lo[3:0];
    end else begin
      s1_d.lo_cb  = (add_adj[5:4] != 2'd0);
      s1_d.lo_nib = add_adj[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

/* hw/rtl/bcdalu_hi.sv */
// Second pipeline stage: high nibble arithmetic, binary result, carry and overflow.
`timescale 1ns / 1ps

module bcdalu_hi
  import bcdalu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  bcdalu_s1_t s1_i,
  output logic       valid_o,
  output bcdalu_s2_t s2_o
);

  logic       valid_q;
  bcdalu_s2_t s2_d, s2_q;
  logic [8:0] bin_add;
  logic [8:0] bin_sub;
  logic [4:0] hi_add;
  logic [4:0] hi_sub;
  logic [7:0] dec_add;
  logic       borrow;

  always_comb begin
    borrow  = ~s1_i.cin;
    bin_add = {1'b0, s1_i.acc} + {1'b0, s1_i.opnd} + {8'd0, s1_i.cin};
    bin_sub = {1'b0, s1_i.acc} - {1'b0, s1_i.opnd} - {8'd0, borrow};
    hi_add  = {1'b0, s1_i.acc[7:4]} + {1'b0, s1_i.opnd[7:4]} + {4'd0, s1_i.lo_cb};
    hi_sub  = {1'b0, s1_i.acc[7:4]} - {1'b0, s1_i.opnd[7:4]} - {4'd0, s1_i.lo_cb};
    dec_add = {hi_add[3:0], s1_i.lo_nib};

    s2_d.func   = s1_i.func;
    s2_d.dec    = s1_i.dec;
    s2_d.lo_nib = s1_i.lo_nib;
    if (s1_i.func == FuncSbc) begin
      s2_d.hi_part = hi_sub;
      s2_d.bin_res = bin_sub[7:0];
      s2_d.bin_c   = ~bin_sub[8];
      s2_d.ovf     = (s1_i.acc[7] ^ s1_i.opnd[7]) & (s1_i.acc[7] ^ bin_sub[7]);
    end else begin
      s2_d.hi_part = hi_add;
      s2_d.bin_res = bin_add[7:0];
      s2_d.bin_c   = bin_add[8];
      if (s1_i.dec) begin
        s2_d.ovf = ~(s1_i.acc[7] ^ s1_i.opnd[7]) & (s1_i.acc[7] ^ dec_add[7]);
      end else begin
        s2_d.ovf = ~(s1_i.acc[7] ^ s1_i.opnd[7]) & (s1_i.acc[7] ^ bin_add[7]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q <= s2_d;
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

/* hw/rtl/bcdalu_fix.sv */
// Third pipeline stage: high digit decimal correction, result selection and flags.
`timescale 1ns / 1ps

module bcdalu_fix
  import bcdalu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  bcdalu_s2_t  s2_i,
  output logic        valid_o,
  output bcdalu_res_t res_o
);

  logic        valid_q;
  bcdalu_res_t res_d, res_q;
  logic [5:0]  hi_adj;
  logic [7:0]  value;
  logic        carry;

  always_comb begin
    hi_adj = (s2_i.hi_part > {1'b0, BcdMaxDigit}) ? ({1'b0, s2_i.hi_part} + {2'd0, BcdAdjust})
                                                   : {1'b0, s2_i.hi_part};
    if (!s2_i.dec) begin
      value = s2_i.bin_res;
      carry = s2_i.bin_c;
    end else if (s2_i.func == FuncSbc) begin
      value = {(s2_i.hi_part[4] ? (s2_i.hi_part[3:0] - BcdAdjust) : s2_i.hi_part[3:0]),
               s2_i.lo_nib};
      carry = s2_i.bin_c;
    end else begin
      value = {hi_adj[3:0], s2_i.lo_nib};
      carry = (hi_adj[5:4] != 2'd0);
    end

    res_d.acc_out      = value;
    res_d.carry_out    = carry;
    res_d.overflow_out = s2_i.ovf;
    res_d.negative_out = value[7];
    res_d.zero_out     = (value == 8'd0);
    res_d.extra_cycle  = s2_i.dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* hw/rtl/bcd_add_subtract_alu_top.sv */
// Top level of the three-stage binary and packed-BCD add/subtract ALU.
// Each accepted request passes the lo, hi and fix stage registers in turn, one register per
// stage, and its result is then driven on res_o together with valid_o.
// Throughput: one request per cycle; busy_o stays low, so every cycle may start one.
// The result strobe valid_o is high for exactly one cycle and cannot be held off.
// Reset clears the stage valid bits asynchronously; requests in flight are dropped.
`timescale 1ns / 1ps

module bcd_add_subtract_alu_top
  import bcdalu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  bcdalu_req_t req_i,
  output logic        valid_o,
  output bcdalu_res_t res_o
);

  logic       s1_valid;
  logic       s2_valid;
  bcdalu_s1_t s1;
  bcdalu_s2_t s2;
  logic       accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  bcdalu_lo u_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .valid_o (s1_valid),
    .s1_o    (s1)
  );

  bcdalu_hi u_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .s1_i    (s1),
    .valid_o (s2_valid),
    .s2_o    (s2)
  );

  bcdalu_fix u_fix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .s2_i    (s2),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule

/* hw/rtl/bcdalu_checker.sv */
// Port-level assertions for the BCD add/subtract ALU, bound to the top level.
`timescale 1ns / 1ps

module bcdalu_checker
  import bcdalu_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input bcdalu_req_t req_i,
  input logic        valid_o,
  input bcdalu_res_t res_o
);

  // Every accepted request later produces a result on valid_o.
  a_req_to_res : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 valid_o)
    else $error("accepted request produced no result");

  // No result appears without a matching earlier accepted request.
  a_res_from_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, 3))
    else $error("result without a matching request");

  // The extra decimal cycle flag follows the decimal mode of the originating request.
  a_extra_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (res_o.extra_cycle == $past(req_i.decimal_mode, 3)))
    else $error("extra cycle flag does not match decimal mode");

  // Negative and zero flags agree with the delivered accumulator.
  a_nz_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((res_o.negative_out == res_o.acc_out[7]) &&
                 (res_o.zero_out == (res_o.acc_out == 8'd0))))
    else $error("N or Z flag inconsistent with result");

endmodule

bind bcd_add_subtract_alu_top bcdalu_checker u_bcdalu_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .req_i   (req_i),
  .valid_o (valid_o),
  .res_o   (res_o)
);
